// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while the given reset is high
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while the given reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// shared types, constants and helpers of the range minimum segment tree
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int IdxW = 10;
  localparam int ValueW = 32;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [IdxW-1:0] index_t;

  // largest value, also the reset value of every node
  localparam value_t TopValue = 32'sh7fffffff;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    value_t min_value;
    logic span_empty;
  } result_t;

  function automatic value_t lesser(value_t a, value_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/range_min_segment_tree.sv =====
// update: one node written per level in the engine, from the leaf up to the root
// query: at most two node reads per level, result passed on to the output register
// empty or reversed span: straight to the finish state; one transaction in the engine at a time
// reset: the engine sweeps all 2*2^LEVELS nodes to the top value with in_ready
//   low before the first transaction is taken
// ----------------------------------------------------------------------------
// range_min_segment_tree
// segment tree range minimum store with point update and range query
// ----------------------------------------------------------------------------
module range_min_segment_tree #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  rmst_pkg::index_t first_index,
  input  rmst_pkg::index_t last_index,
  input  rmst_pkg::value_t new_value,
  output logic             out_valid,
  input  logic             out_ready,
  output rmst_pkg::value_t min_value,
  output logic             span_empty
);
  import rmst_pkg::*;

  // tree is padded to a power of two of leaves, heap layout with root at
  // node 1 and leaf p at node 2^LEVELS + p; padding leaves stay at the top
  // value and so never lower a minimum
  localparam int LEVELS = $clog2(LEAF_COUNT);
  localparam int AW = LEVELS + 1;
  localparam int NODES = 2 ** AW;

  logic          fin_valid;
  logic          fin_ready;
  result_t       fin;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic          rd_a_en;
  logic [AW-1:0] rd_a_addr;
  value_t        rd_a_data;
  logic          rd_b_en;
  logic [AW-1:0] rd_b_addr;
  value_t        rd_b_data;

  rmst_engine #(
    .LEAF_COUNT(LEAF_COUNT)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .first_index (first_index),
    .last_index  (last_index),
    .new_value   (new_value),
    .fin_valid   (fin_valid),
    .fin_ready   (fin_ready),
    .fin         (fin),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .rd_a_en     (rd_a_en),
    .rd_a_addr   (rd_a_addr),
    .rd_a_data   (rd_a_data),
    .rd_b_en     (rd_b_en),
    .rd_b_addr   (rd_b_addr),
    .rd_b_data   (rd_b_data)
  );

  // two copies of the node store, always written together, so a query can
  // fetch the left and right boundary nodes of one level in the same cycle
  rmst_ram #(
    .WIDTH(ValueW),
    .DEPTH(NODES)
  ) u_ram_a (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_a_en),
    .raddr (rd_a_addr),
    .rdata (rd_a_data)
  );

  rmst_ram #(
    .WIDTH(ValueW),
    .DEPTH(NODES)
  ) u_ram_b (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_b_en),
    .raddr (rd_b_addr),
    .rdata (rd_b_data)
  );

  // output register decouples the result from the next transaction
  assign fin_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      min_value  <= fin.min_value;
      span_empty <= fin.span_empty;
    end
  end

endmodule

// ===== rtl/core/rmst_ram.sv =====
// ----------------------------------------------------------------------------
// rmst_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rmst_engine.sv =====
// ----------------------------------------------------------------------------
// rmst_engine
// sequencer for clearing, bottom-up point update and bottom-up range query
// ----------------------------------------------------------------------------
module rmst_engine #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               func,
  input  rmst_pkg::index_t                   first_index,
  input  rmst_pkg::index_t                   last_index,
  input  rmst_pkg::value_t                   new_value,
  output logic                               fin_valid,
  input  logic                               fin_ready,
  output rmst_pkg::result_t                  fin,
  output logic                               mem_we,
  output logic [$clog2(LEAF_COUNT):0]        mem_waddr,
  output rmst_pkg::value_t                   mem_wdata,
  output logic                               rd_a_en,
  output logic [$clog2(LEAF_COUNT):0]        rd_a_addr,
  input  rmst_pkg::value_t                   rd_a_data,
  output logic                               rd_b_en,
  output logic [$clog2(LEAF_COUNT):0]        rd_b_addr,
  input  rmst_pkg::value_t                   rd_b_data
);
  import rmst_pkg::*;

  localparam int LW = $clog2(LEAF_COUNT);
  localparam int AW = LW + 1;
  localparam int IW = AW + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_QRY   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [AW-1:0] node, node_next;
  value_t        acc, acc_next;
  logic [IW-1:0] lo, lo_next;
  logic [IW-1:0] hi, hi_next;
  logic          pend_a, pend_a_next;
  logic          pend_b, pend_b_next;
  logic          empty_flag, empty_flag_next;

  logic          first_ok;
  logic          last_over;
  logic [LW-1:0] first_pos;
  logic [LW-1:0] last_pos;
  logic [AW-1:0] leaf_addr;
  logic [AW-1:0] parent;
  logic          take_a;
  logic          take_b;
  value_t        upd_min;
  value_t        qry_min;

  assign first_ok  = int'(first_index) < LEAF_COUNT;
  assign last_over = int'(last_index) > (LEAF_COUNT - 1);
  assign first_pos = LW'(first_index);
  assign last_pos  = last_over ? LW'(LEAF_COUNT - 1) : LW'(last_index);
  assign leaf_addr = {1'b1, first_pos};
  assign parent    = node >> 1;
  assign take_a    = lo[0];
  assign take_b    = ~hi[0];
  assign upd_min   = lesser(acc, rd_a_data);
  assign qry_min   = lesser(lesser(acc, pend_a ? rd_a_data : TopValue),
                            pend_b ? rd_b_data : TopValue);

  assign fin.min_value  = acc;
  assign fin.span_empty = empty_flag;

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    node_next       = node;
    acc_next        = acc;
    lo_next         = lo;
    hi_next         = hi;
    pend_a_next     = pend_a;
    pend_b_next     = pend_b;
    empty_flag_next = empty_flag;
    in_ready        = 1'b0;
    fin_valid       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = TopValue;
    rd_a_en         = 1'b0;
    rd_a_addr       = '0;
    rd_b_en         = 1'b0;
    rd_b_addr       = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_UPDATE) begin
            if (first_ok) begin
              mem_we     = 1'b1;
              mem_waddr  = leaf_addr;
              mem_wdata  = new_value;
              rd_a_en    = 1'b1;
              rd_a_addr  = leaf_addr ^ AW'(1);
              node_next  = leaf_addr;
              acc_next   = new_value;
              state_next = S_UPD;
            end
          end else begin
            acc_next    = TopValue;
            pend_a_next = 1'b0;
            pend_b_next = 1'b0;
            if (first_index > last_index || !first_ok) begin
              empty_flag_next = 1'b1;
              state_next      = S_FIN;
            end else begin
              empty_flag_next = 1'b0;
              lo_next         = {2'b01, first_pos};
              hi_next         = {2'b01, last_pos};
              state_next      = S_QRY;
            end
          end
        end
      end
      S_UPD: begin
        // sibling arrived, refresh the parent and fetch the next sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = upd_min;
        acc_next  = upd_min;
        node_next = parent;
        if (parent == AW'(1)) begin
          state_next = S_IDLE;
        end else begin
          rd_a_en   = 1'b1;
          rd_a_addr = parent ^ AW'(1);
        end
      end
      S_QRY: begin
        acc_next = qry_min;
        if (lo <= hi) begin
          rd_a_en     = take_a;
          rd_a_addr   = lo[AW-1:0];
          rd_b_en     = take_b;
          rd_b_addr   = hi[AW-1:0];
          pend_a_next = take_a;
          pend_b_next = take_b;
          lo_next     = (lo + IW'(take_a)) >> 1;
          hi_next     = (hi - IW'(take_b)) >> 1;
        end else begin
          pend_a_next = 1'b0;
          pend_b_next = 1'b0;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        fin_valid = 1'b1;
        if (fin_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pend_a   <= 1'b0;
      pend_b   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend_a   <= pend_a_next;
      pend_b   <= pend_b_next;
    end
  end

  always_ff @(posedge clk) begin
    node       <= node_next;
    acc        <= acc_next;
    lo         <= lo_next;
    hi         <= hi_next;
    empty_flag <= empty_flag_next;
  end

endmodule

// ===== rtl/core/rmst_checker.sv =====
// ----------------------------------------------------------------------------
// rmst_checker
// port-level assertions for the range minimum segment tree
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmst_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rmst_pkg::value_t min_value,
  input logic             span_empty
);
  import rmst_pkg::*;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(min_value) && $stable(span_empty))

  // an empty span always reports the top value
  `ASSERT_IMP(a_empty_top, clk, rst, out_valid && span_empty, min_value == TopValue)

  // node sweep after reset keeps the input closed
  `ASSERT_NEXT(a_clear_closed, clk, 1'b0, rst, !in_ready)

  // one transaction at a time in the engine
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the range minimum segment tree: point updates and span queries are
// streamed through the valid/ready ports while a flat array of leaf values
// predicts every query result, which is compared field by field on arrival
// ----------------------------------------------------------------------------
module tb;
  import rmst_pkg::*;

  localparam int LeafCount = 1024;
  localparam int RandomOps = 1100;
  localparam int CycleLimit = 400000;
  localparam int QuietTail = 150;       // last items go through with no idling
  localparam int HoldOffAt = 300;       // transaction count that starts the long hold-off
  localparam int HoldOffCycles = 250;
  localparam int DrainCycles = 40;
  localparam int ReportMax = 10;

  typedef struct packed {
    logic   func;
    index_t first;
    index_t last;
    value_t val;
  } tree_op_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   func = FUNC_UPDATE;
  index_t first_index = '0;
  index_t last_index = '0;
  value_t new_value = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  value_t min_value;
  logic   span_empty;

  always #10 clk = ~clk;

  range_min_segment_tree #(
    .LEAF_COUNT(LeafCount)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .first_index(first_index),
    .last_index(last_index),
    .new_value(new_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .min_value(min_value),
    .span_empty(span_empty)
  );

  // predicted contents of the leaves; inner nodes are just minima of these
  value_t   leaf_value [LeafCount];
  tree_op_t op_queue [$];
  result_t  expected_minima [$];

  logic in_fire = 1'b0;
  int   accepted_ops = 0;
  int   n_updates = 0;
  int   n_queries = 0;
  int   n_empty = 0;
  int   n_checked = 0;
  int   n_mismatch = 0;
  int   cycle_count = 0;
  int   send_gap = 0;
  int   recv_stall = 0;
  bit   hold_off_done = 1'b0;

  // idling pauses every fourth stretch of 120 transactions and in the tail
  function automatic bit idling_on();
    return (op_queue.size() > QuietTail) && ((accepted_ops / 120) % 4 != 3);
  endfunction

  task automatic note_mismatch(string msg);
    n_mismatch++;
    if (n_mismatch <= ReportMax) $display("mismatch: %s", msg);
  endtask

  task automatic add_op(logic f, int first, int last, value_t v);
    tree_op_t op;
    op.func = f;
    op.first = index_t'(first);
    op.last = index_t'(last);
    op.val = v;
    op_queue.insert(op_queue.size(), op);
  endtask

  // sender: a new transaction is offered only after the last one was taken
  always @(negedge clk) begin
    tree_op_t nxt;
    if (!rst) begin
      if (in_valid && !in_fire) begin
        // still waiting for the block to take it
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (op_queue.size() != 0 && idling_on() && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 12) - 1;
        in_valid <= 1'b0;
      end else if (op_queue.size() != 0) begin
        nxt = op_queue.pop_front();
        in_valid <= 1'b1;
        func <= nxt.func;
        first_index <= nxt.first;
        last_index <= nxt.last;
        new_value <= nxt.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls plus one long hold-off once HoldOffAt transactions are taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_off_done && accepted_ops >= HoldOffAt) begin
        hold_off_done = 1'b1;
        recv_stall = HoldOffCycles - 1;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: checks results first, then predicts from the accepted transaction
  always @(posedge clk) begin
    result_t want;
    value_t  running;
    cycle_count <= cycle_count + 1;
    in_fire <= !rst && in_valid && in_ready;

    if (!rst && out_valid && out_ready) begin
      if (expected_minima.size() == 0) begin
        note_mismatch($sformatf("result min %0d empty %0b with nothing expected",
                                min_value, span_empty));
      end else begin
        want = expected_minima.pop_front();
        n_checked++;
        if (min_value !== want.min_value)
          note_mismatch($sformatf("min_value expected %0d got %0d",
                                  want.min_value, min_value));
        if (span_empty !== want.span_empty)
          note_mismatch($sformatf("span_empty expected %0b got %0b",
                                  want.span_empty, span_empty));
      end
    end

    if (!rst && in_valid && in_ready) begin
      accepted_ops <= accepted_ops + 1;
      if (func == FUNC_UPDATE) begin
        // with 1024 leaves every 10-bit index is a real position
        leaf_value[first_index] = new_value;
        n_updates++;
      end else begin
        n_queries++;
        if (first_index > last_index) begin
          want.min_value = TopValue;
          want.span_empty = 1'b1;
          n_empty++;
        end else begin
          running = TopValue;
          for (int k = first_index; k <= last_index; k++)
            if (leaf_value[k] < running) running = leaf_value[k];
          want.min_value = running;
          want.span_empty = 1'b0;
        end
        expected_minima.insert(expected_minima.size(), want);
      end
    end

    if (cycle_count >= CycleLimit) begin
      $display("run stopped at the cycle limit with %0d results outstanding",
               expected_minima.size());
      $display("FAIL range_min_segment_tree");
      $finish;
    end
  end

  initial begin
    int     kind;
    int     first;
    int     span;
    int     total_ops;
    value_t v;

    for (int k = 0; k < LeafCount; k++) leaf_value[k] = TopValue;

    // directed: empty tree, extremes, reversed spans, overwrite raising the minimum
    add_op(FUNC_QUERY, 0, 1023, $urandom);
    add_op(FUNC_QUERY, 5, 4, $urandom);
    add_op(FUNC_QUERY, 1023, 0, $urandom);
    add_op(FUNC_QUERY, 0, 0, $urandom);
    add_op(FUNC_UPDATE, 0, 1023, 32'sh80000000);
    add_op(FUNC_UPDATE, 1023, 0, TopValue);
    add_op(FUNC_UPDATE, 512, $urandom_range(0, 1023), -1);
    add_op(FUNC_UPDATE, 511, $urandom_range(0, 1023), 0);
    add_op(FUNC_UPDATE, 1, $urandom_range(0, 1023), 32'sh7ffffffe);
    add_op(FUNC_QUERY, 0, 1023, $urandom);
    add_op(FUNC_QUERY, 1, 1023, $urandom);
    add_op(FUNC_QUERY, 1023, 1023, $urandom);
    add_op(FUNC_QUERY, 511, 511, $urandom);
    add_op(FUNC_QUERY, 513, 1022, $urandom);
    add_op(FUNC_QUERY, 1, 511, $urandom);
    add_op(FUNC_QUERY, 512, 1023, $urandom);
    add_op(FUNC_UPDATE, 0, 1023, 5);
    add_op(FUNC_QUERY, 0, 1023, $urandom);
    add_op(FUNC_QUERY, 0, 0, $urandom);
    add_op(FUNC_UPDATE, 1023, 1023, 32'sh80000000);
    add_op(FUNC_QUERY, 600, 1023, $urandom);
    add_op(FUNC_QUERY, 1000, 999, $urandom);
    add_op(FUNC_QUERY, 1022, 1023, $urandom);
    add_op(FUNC_QUERY, 1023, 1023, $urandom);

    // random mix: updates, reversed spans, and spans from one leaf to the whole tree
    for (int i = 0; i < RandomOps; i++) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: v = TopValue;
        1: v = 32'sh80000000;
        2, 3: v = value_t'($urandom_range(0, 2000)) - 1000;
        default: v = $urandom;
      endcase
      if (kind < 45) begin
        add_op(FUNC_UPDATE, $urandom_range(0, 1023), $urandom_range(0, 1023), v);
      end else if (kind < 55) begin
        first = $urandom_range(1, 1023);
        add_op(FUNC_QUERY, first, $urandom_range(0, first - 1), v);
      end else begin
        first = $urandom_range(0, 1023);
        case ($urandom_range(0, 3))
          0: span = 0;
          1: span = $urandom_range(0, 8);
          2: span = $urandom_range(0, 64);
          default: span = $urandom_range(0, 1023);
        endcase
        if (first + span > 1023) span = 1023 - first;
        add_op(FUNC_QUERY, first, first + span, v);
      end
    end
    total_ops = op_queue.size();

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // every transaction taken by the block, then every result drained
    while (accepted_ops < total_ops) @(negedge clk);
    while (expected_minima.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("%0d updates and %0d range queries sent, %0d results checked, %0d of them empty",
             n_updates, n_queries, n_checked, n_empty);
    $display("random idling on both sides, one %0d-cycle output hold-off, %0d cycles in all",
             HoldOffCycles, cycle_count);
    if (n_mismatch == 0 && expected_minima.size() == 0) begin
      $display("PASS range_min_segment_tree");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("FAIL range_min_segment_tree");
    end
    $finish;
  end

endmodule
